/* rtl/rrts_pkg.sv */
// rrts_pkg: shared types for the round-robin task scheduler
// operation codes, controller states and the command/status bundles
// no dependencies
`default_nettype none

package rrts_pkg;

   // operation codes carried on req_func
   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_SCHED = 2'd1,
      FUNC_TERM  = 2'd2,
      FUNC_YIELD = 2'd3
   } func_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WSTART,
      S_WALK,
      S_CHK_RD,
      S_CHK_EV,
      S_CTX_RD,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch the request word
      logic do_simple;   // add, terminate or set yield
      logic walk_start;  // load the walk pointer and counters
      logic walk_run;    // issue and evaluate table entries
      logic chk_rd;      // read flags of the old current entry
      logic chk_ev;      // save context, commit the pick
      logic ctx_rd;      // read the picked context
      logic load_rsp;    // load the response word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic table_empty;
      logic walk_found;
      logic walk_done;
   } status_type;

endpackage

`default_nettype wire

/* rtl/round_robin_task_scheduler.sv */
// round_robin_task_scheduler: top level of the task scheduler
// joins the sequencer rrts_ctrl and the table datapath rrts_datapath
// depends on rrts_pkg, rrts_ctrl, rrts_datapath
`default_nettype none

// Round-robin scheduler over a table of MAX_TASKS entries. One request word is
// taken at a time. Add, terminate and set yield pass through S_EXEC to S_FINISH,
// which loads the response word and returns to idle to accept the next word. A
// schedule walks the table one entry per cycle through a pipelined read of the
// flag memories, starting after the current entry and wrapping. A pick passes
// through S_CHK_RD, S_CHK_EV and S_CTX_RD before S_FINISH loads the response;
// a walk that picks nothing, or an empty table from S_WSTART, goes straight to
// S_FINISH. The response sits in an output register, so it may wait on rsp_stall
// while the sequencer returns to idle and accepts the next word; that word then
// holds in its last state until the register frees. No clearing pass follows
// reset.

module round_robin_task_scheduler #(
   parameter int MAX_TASKS = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_func,
   input  wire  [31:0] req_context_in,
   input  wire         req_new_is_thread,
   input  wire  [7:0]  req_target_task,
   input  wire         req_yield_value,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_chosen_task,
   output logic [31:0] rsp_context_out
);
   import rrts_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // task table and response word
   rrts_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_context_in    (req_context_in),
      .req_new_is_thread (req_new_is_thread),
      .req_target_task   (req_target_task),
      .req_yield_value   (req_yield_value),
      .rsp_accepted      (rsp_accepted),
      .rsp_chosen_task   (rsp_chosen_task),
      .rsp_context_out   (rsp_context_out),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire

/* rtl/rrts_ctrl.sv */
// rrts_ctrl: sequencer for the round-robin task scheduler
// drives the datapath commands and the handshake of both channels
// depends on rrts_pkg
`default_nettype none

module rrts_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire [1:0]           req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output rrts_pkg::cmd_type   cmd,
   input  rrts_pkg::status_type status
);
   import rrts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // state and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (func_type'(req_func) == FUNC_SCHED) begin
                  state_in = S_WSTART;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            cmd.do_simple = 1'b1;
            state_in = S_FINISH;
         end
         S_WSTART: begin
            cmd.walk_start = 1'b1;
            if (status.table_empty) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_run = 1'b1;
            if (status.walk_found) begin
               state_in = S_CHK_RD;
            end else if (status.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_CHK_RD: begin
            cmd.chk_rd = 1'b1;
            state_in = S_CHK_EV;
         end
         S_CHK_EV: begin
            cmd.chk_ev = 1'b1;
            state_in = S_CTX_RD;
         end
         S_CTX_RD: begin
            cmd.ctx_rd = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // an accepted word always starts work
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted word did not start work");

   // a response appears only out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("response raised outside finish state");

   // the walk keeps going until it finds an entry or runs out
   a_walk_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && !status.walk_found && !status.walk_done)
      |=> (state_ff == S_WALK))
      else $error("walk left early");
`endif

endmodule

`default_nettype wire

/* rtl/rrts_datapath.sv */
// rrts_datapath: task table, walk pointer and response word
// holds context and flag memories, task count and current entry
// depends on rrts_pkg
`default_nettype none

module rrts_datapath #(
   parameter int MAX_TASKS = 256
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [1:0]            req_func,
   input  wire [31:0]           req_context_in,
   input  wire                  req_new_is_thread,
   input  wire [7:0]            req_target_task,
   input  wire                  req_yield_value,
   output logic                 rsp_accepted,
   output logic [7:0]           rsp_chosen_task,
   output logic [31:0]          rsp_context_out,
   input  rrts_pkg::cmd_type    cmd,
   output rrts_pkg::status_type status
);
   import rrts_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int TW = (CW > 8) ? CW : 8;

   // table memories
   logic [31:0] ctx_mem  [MAX_TASKS];
   logic        pres_mem [MAX_TASKS];
   logic        thr_mem  [MAX_TASKS];
   logic        fin_mem  [MAX_TASKS];
   logic        yld_mem  [MAX_TASKS];

   // captured request word
   func_type    func_ff;
   logic [31:0] ctx_in_ff;
   logic        thr_ff;
   logic [7:0]  tgt_ff;
   logic        yv_ff;

   // scheduler state
   logic [CW-1:0] task_count_ff, task_count_in;
   logic [IW-1:0] current_index_ff, current_index_in;
   logic          current_valid_ff, current_valid_in;

   // walk pipeline
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] issue_left_ff, issue_left_in;
   logic          ev_valid_ff, ev_valid_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;
   logic [IW-1:0] pick_idx_ff, pick_idx_in;

   // result bookkeeping
   logic acc_ff, acc_in;
   logic use_fetch_ff, use_fetch_in;

   // memory ports
   logic          ctx_we, ctx_re;
   logic [IW-1:0] ctx_waddr, ctx_raddr;
   logic [31:0]   ctx_wdata, ctx_rd_ff;
   logic          flag_re;
   logic [IW-1:0] flag_raddr;
   logic          pres_rd_ff, thr_rd_ff, fin_rd_ff, yld_rd_ff;
   logic          pres_we, pres_wdata;
   logic [IW-1:0] pres_waddr;
   logic          thr_we;
   logic          fin_we, fin_wdata;
   logic [IW-1:0] fin_waddr;
   logic          yld_we, yld_wdata;
   logic [IW-1:0] yld_waddr;

   // helpers
   logic          table_full;
   logic [CW-1:0] cnt_m1;
   logic [IW-1:0] walk_base;
   logic [TW-1:0] tgt_ext, cnt_ext, cur_ext;
   logic          yield_hit;
   logic          ev_retire, ev_found;

   // step to the following entry with wrap at the task count
   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] n);
      logic [CW-1:0] inc;
      inc = CW'(idx) + CW'(1);
      if (inc == n) begin
         return '0;
      end
      return inc[IW-1:0];
   endfunction

   assign table_full = (task_count_ff == CW'(MAX_TASKS));
   assign cnt_m1     = task_count_ff - CW'(1);
   assign walk_base  = current_valid_ff ? current_index_ff : cnt_m1[IW-1:0];
   assign tgt_ext    = TW'(tgt_ff);
   assign cnt_ext    = TW'(task_count_ff);
   assign cur_ext    = TW'(current_index_ff);
   assign yield_hit  = (tgt_ext < cnt_ext);

   // evaluate the entry whose flags just came back
   assign ev_retire = ev_valid_ff && pres_rd_ff && thr_rd_ff && fin_rd_ff;
   assign ev_found  = ev_valid_ff && pres_rd_ff &&
                      !(thr_rd_ff && (fin_rd_ff || yld_rd_ff));

   assign status.table_empty = (task_count_ff == '0);
   assign status.walk_found  = ev_found;
   assign status.walk_done   = (issue_left_ff == '0) && !ev_valid_ff;

   // capture the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= func_type'(req_func);
         ctx_in_ff <= req_context_in;
         thr_ff    <= req_new_is_thread;
         tgt_ff    <= req_target_task;
         yv_ff     <= req_yield_value;
      end
   end

   // next values for state, walk and memory ports
   always_comb begin
      task_count_in    = task_count_ff;
      current_index_in = current_index_ff;
      current_valid_in = current_valid_ff;
      rd_idx_in        = rd_idx_ff;
      issue_left_in    = issue_left_ff;
      ev_valid_in      = 1'b0;
      ev_idx_in        = rd_idx_ff;
      pick_idx_in      = pick_idx_ff;
      acc_in           = acc_ff;
      use_fetch_in     = use_fetch_ff;
      ctx_we     = 1'b0;
      ctx_waddr  = task_count_ff[IW-1:0];
      ctx_wdata  = ctx_in_ff;
      ctx_re     = cmd.ctx_rd;
      ctx_raddr  = current_index_ff;
      flag_re    = 1'b0;
      flag_raddr = rd_idx_ff;
      pres_we    = 1'b0;
      pres_wdata = 1'b1;
      pres_waddr = task_count_ff[IW-1:0];
      thr_we     = 1'b0;
      fin_we     = 1'b0;
      fin_wdata  = 1'b0;
      fin_waddr  = task_count_ff[IW-1:0];
      yld_we     = 1'b0;
      yld_wdata  = 1'b0;
      yld_waddr  = task_count_ff[IW-1:0];

      // add, terminate, set yield
      if (cmd.do_simple) begin
         acc_in       = 1'b1;
         use_fetch_in = 1'b0;
         case (func_ff)
            FUNC_ADD: begin
               if (table_full) begin
                  acc_in = 1'b0;
               end else begin
                  ctx_we  = 1'b1;
                  pres_we = 1'b1;
                  thr_we  = 1'b1;
                  fin_we  = 1'b1;
                  yld_we  = 1'b1;
                  task_count_in = task_count_ff + CW'(1);
               end
            end
            FUNC_TERM: begin
               fin_we    = current_valid_ff;
               fin_wdata = 1'b1;
               fin_waddr = current_index_ff;
            end
            FUNC_YIELD: begin
               yld_we    = yield_hit;
               yld_wdata = yv_ff;
               yld_waddr = tgt_ext[IW-1:0];
            end
            default: begin
            end
         endcase
      end

      // walk setup: nothing picked until proven otherwise
      if (cmd.walk_start) begin
         acc_in        = 1'b0;
         use_fetch_in  = 1'b0;
         rd_idx_in     = next_idx(walk_base, task_count_ff);
         issue_left_in = task_count_ff;
      end

      // walk: issue one read and evaluate one entry per cycle
      if (cmd.walk_run) begin
         if (issue_left_ff != '0) begin
            flag_re       = 1'b1;
            ev_valid_in   = 1'b1;
            ev_idx_in     = rd_idx_ff;
            rd_idx_in     = next_idx(rd_idx_ff, task_count_ff);
            issue_left_in = issue_left_ff - CW'(1);
         end
         if (ev_retire) begin
            pres_we    = 1'b1;
            pres_wdata = 1'b0;
            pres_waddr = ev_idx_ff;
         end
         if (ev_found) begin
            pick_idx_in = ev_idx_ff;
         end
      end

      // look up the old current entry
      if (cmd.chk_rd) begin
         flag_re    = 1'b1;
         flag_raddr = current_index_ff;
      end

      // save running context if the old entry survives, then switch
      if (cmd.chk_ev) begin
         ctx_we           = current_valid_ff && pres_rd_ff;
         ctx_waddr        = current_index_ff;
         current_index_in = pick_idx_ff;
         current_valid_in = 1'b1;
         acc_in           = 1'b1;
         use_fetch_in     = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff    <= '0;
         current_index_ff <= '0;
         current_valid_ff <= 1'b0;
         issue_left_ff    <= '0;
         ev_valid_ff      <= 1'b0;
      end else begin
         task_count_ff    <= task_count_in;
         current_index_ff <= current_index_in;
         current_valid_ff <= current_valid_in;
         issue_left_ff    <= issue_left_in;
         ev_valid_ff      <= ev_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      ev_idx_ff    <= ev_idx_in;
      pick_idx_ff  <= pick_idx_in;
      acc_ff       <= acc_in;
      use_fetch_ff <= use_fetch_in;
   end

   // context memory
   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[ctx_waddr] <= ctx_wdata;
      end
      if (ctx_re) begin
         ctx_rd_ff <= ctx_mem[ctx_raddr];
      end
   end

   // present flag memory
   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_waddr] <= pres_wdata;
      end
      if (flag_re) begin
         pres_rd_ff <= pres_mem[flag_raddr];
      end
   end

   // thread flag memory
   always_ff @(posedge clock) begin
      if (thr_we) begin
         thr_mem[task_count_ff[IW-1:0]] <= thr_ff;
      end
      if (flag_re) begin
         thr_rd_ff <= thr_mem[flag_raddr];
      end
   end

   // finished flag memory
   always_ff @(posedge clock) begin
      if (fin_we) begin
         fin_mem[fin_waddr] <= fin_wdata;
      end
      if (flag_re) begin
         fin_rd_ff <= fin_mem[flag_raddr];
      end
   end

   // yield flag memory
   always_ff @(posedge clock) begin
      if (yld_we) begin
         yld_mem[yld_waddr] <= yld_wdata;
      end
      if (flag_re) begin
         yld_rd_ff <= yld_mem[flag_raddr];
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted    <= acc_ff;
         rsp_chosen_task <= cur_ext[7:0];
         rsp_context_out <= use_fetch_ff ? ctx_rd_ff : ctx_in_ff;
      end
   end

`ifndef SYNTH
   // the table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (task_count_ff <= CW'(MAX_TASKS)))
      else $error("task count past table depth");

   // a running task always lies inside the table
   a_current_inside: assert property (@(posedge clock) disable iff (reset)
      current_valid_ff |-> (CW'(current_index_ff) < task_count_ff))
      else $error("current entry outside table");

   // the table only grows by one per add
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (task_count_ff != $past(task_count_ff)) |->
      (task_count_ff == $past(task_count_ff) + CW'(1)))
      else $error("task count jumped");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for round_robin_task_scheduler
// drives request words from a queue, predicts each response and checks it in order
// depends on rrts_pkg and the scheduler rtl
`timescale 1ns / 100ps

module testbench;
   import rrts_pkg::*;

   localparam int MAX_TASKS   = 256;
   localparam int IDLE_PCT    = 28;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE      = 300;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int QUIET_LO    = 100;
   localparam int QUIET_HI    = 160;

   // flag bit positions of one table entry
   localparam int BIT_PRESENT  = 0;
   localparam int BIT_THREAD   = 1;
   localparam int BIT_FINISHED = 2;
   localparam int BIT_YIELD    = 3;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_HOLD,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      func_type      func;
      logic [31:0]   ctx;
      logic          thr;
      logic [7:0]    tgt;
      logic          yv;
   } req_word_type;

   typedef struct packed {
      logic        accepted;
      logic [7:0]  chosen_task;
      logic [31:0] context_out;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_ADD;
   logic [31:0] req_context_in = '0;
   logic        req_new_is_thread = 1'b0;
   logic [7:0]  req_target_task = '0;
   logic        req_yield_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   logic [7:0]  rsp_chosen_task;
   logic [31:0] rsp_context_out;

   req_word_type     pending_words[$];
   sched_result_type expected_results[$];

   // predicted scheduler state
   logic [31:0] saved_ctx [MAX_TASKS];
   logic [3:0]  entry_bits [MAX_TASKS];
   logic [8:0]  table_fill = '0;
   logic [7:0]  running_idx = '0;
   logic        running_live = 1'b0;

   int  planned_fill = 0;
   int  words_taken = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   logic hold_go = 1'b0;
   logic req_fire = 1'b0;

   round_robin_task_scheduler #(.MAX_TASKS(MAX_TASKS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_context_in    (req_context_in),
      .req_new_is_thread (req_new_is_thread),
      .req_target_task   (req_target_task),
      .req_yield_value   (req_yield_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_chosen_task   (rsp_chosen_task),
      .rsp_context_out   (rsp_context_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // apply one word to the predicted table and return the response it yields
   function automatic sched_result_type predict_result(func_type f, logic [31:0] c,
                                                       logic t, logic [7:0] g, logic y);
      sched_result_type r;
      int n, base, k;
      logic [7:0] idx, pick;
      logic [3:0] bits;
      logic found;
      r.accepted = 1'b1;
      r.context_out = c;
      case (f)
         FUNC_ADD: begin
            if (table_fill >= MAX_TASKS) begin
               r.accepted = 1'b0;
            end else begin
               saved_ctx[table_fill[7:0]] = c;
               entry_bits[table_fill[7:0]] = '0;
               entry_bits[table_fill[7:0]][BIT_PRESENT] = 1'b1;
               entry_bits[table_fill[7:0]][BIT_THREAD] = t;
               table_fill = table_fill + 9'd1;
            end
         end
         FUNC_SCHED: begin
            r.accepted = 1'b0;
            n = int'(table_fill);
            found = 1'b0;
            pick = '0;
            if (n != 0) begin
               base = running_live ? (running_idx % n) : (n - 1);
               // walk after the current entry, dropping finished threads on the way
               for (k = 1; k <= n && !found; k++) begin
                  idx = 8'((base + k) % n);
                  bits = entry_bits[idx];
                  if (bits[BIT_PRESENT]) begin
                     if (bits[BIT_THREAD] && bits[BIT_FINISHED]) begin
                        entry_bits[idx][BIT_PRESENT] = 1'b0;
                     end else if (!(bits[BIT_THREAD] && bits[BIT_YIELD])) begin
                        found = 1'b1;
                        pick = idx;
                     end
                  end
               end
            end
            if (found) begin
               // save running context unless there was none or it was removed
               if (running_live && entry_bits[running_idx][BIT_PRESENT])
                  saved_ctx[running_idx] = c;
               running_idx = pick;
               running_live = 1'b1;
               r.accepted = 1'b1;
               r.context_out = saved_ctx[pick];
            end
         end
         FUNC_TERM: begin
            if (running_live)
               entry_bits[running_idx][BIT_FINISHED] = 1'b1;
         end
         FUNC_YIELD: begin
            if (g < table_fill)
               entry_bits[g][BIT_YIELD] = y;
         end
         default: begin
         end
      endcase
      r.chosen_task = running_idx;
      return r;
   endfunction

   task automatic queue_word(step_kind_type k, func_type f, logic [31:0] c, logic t,
                             logic [7:0] g, logic y);
      req_word_type w;
      w.kind = k;
      w.func = f;
      w.ctx = c;
      w.thr = t;
      w.tgt = g;
      w.yv = y;
      pending_words.push_back(w);
      if (k == STEP_WORD && f == FUNC_ADD && planned_fill < MAX_TASKS)
         planned_fill++;
   endtask

   // random word, yield targets mostly inside the filled part of the table
   task automatic queue_random_word();
      int pick;
      logic [7:0] g;
      func_type f;
      pick = $urandom_range(0, 99);
      g = 8'($urandom);
      if (planned_fill != 0 && $urandom_range(0, 3) != 0)
         g = 8'($urandom_range(0, planned_fill - 1));
      if (pick < 25)
         f = FUNC_ADD;
      else if (pick < 60)
         f = FUNC_SCHED;
      else if (pick < 75)
         f = FUNC_TERM;
      else
         f = FUNC_YIELD;
      queue_word(STEP_WORD, f, $urandom, 1'($urandom_range(0, 1)), g,
                 1'($urandom_range(0, 1)));
   endtask

   // stimulus plan and end of run
   initial begin
      int i;
      int burst;
      // empty table, no current task, out of range yield
      queue_word(STEP_WORD, FUNC_SCHED, 32'h0000_0000, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_TERM, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_YIELD, 32'h1234_5678, 1'b0, 8'd255, 1'b1);
      // single thread: first pick, then yielded so nothing eligible
      queue_word(STEP_WORD, FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h0000_1111, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_YIELD, 32'h0, 1'b0, 8'd0, 1'b1);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h0000_2222, 1'b0, 8'd0, 1'b0);
      // finish it, walk removes it and finds nothing
      queue_word(STEP_WORD, FUNC_TERM, 32'h0, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h0000_3333, 1'b0, 8'd0, 1'b0);
      // non-thread and thread, pick after the current entry was removed
      queue_word(STEP_WORD, FUNC_ADD, 32'h0000_0000, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_ADD, 32'hA5A5_5A5A, 1'b1, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h0000_4444, 1'b0, 8'd0, 1'b0);
      // yielded thread skipped, wrap back onto the current entry
      queue_word(STEP_WORD, FUNC_YIELD, 32'h0, 1'b0, 8'd2, 1'b1);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h8000_0001, 1'b0, 8'd0, 1'b0);
      // finished and yield flags on a non-thread, yield on a removed entry
      queue_word(STEP_WORD, FUNC_TERM, 32'h0, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h7FFF_FFFE, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_YIELD, 32'h0, 1'b0, 8'd1, 1'b1);
      queue_word(STEP_WORD, FUNC_YIELD, 32'h0, 1'b0, 8'd0, 1'b1);
      queue_word(STEP_WORD, FUNC_YIELD, 32'h0, 1'b0, 8'd2, 1'b0);
      queue_word(STEP_WORD, FUNC_SCHED, 32'h5555_5555, 1'b0, 8'd0, 1'b0);
      // current thread finished, next walk picks before reaching it and saves its context
      queue_word(STEP_WORD, FUNC_TERM, 32'h0, 1'b0, 8'd0, 1'b0);
      queue_word(STEP_WORD, FUNC_SCHED, 32'hAAAA_AAAA, 1'b0, 8'd0, 1'b0);

      for (i = 0; i < 200; i++)
         queue_random_word();
      // receiver holds off while adds fill the table past full
      queue_word(STEP_HOLD, FUNC_ADD, 32'h0, 1'b0, 8'd0, 1'b0);
      burst = MAX_TASKS - planned_fill + 4;
      for (i = 0; i < burst; i++)
         queue_word(STEP_WORD, FUNC_ADD, $urandom, 1'($urandom_range(0, 1)),
                    8'($urandom), 1'($urandom_range(0, 1)));
      // sender waits for every response before going on
      queue_word(STEP_DRAIN, FUNC_ADD, 32'h0, 1'b0, 8'd0, 1'b0);
      for (i = 0; i < 125; i++)
         queue_random_word();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // request driver, updates at the falling edge
   always @(negedge clock) begin
      req_word_type nxt;
      logic go_valid;
      logic go_hold;
      nxt.kind = STEP_WORD;
      nxt.func = func_type'(req_func);
      nxt.ctx = req_context_in;
      nxt.thr = req_new_is_thread;
      nxt.tgt = req_target_task;
      nxt.yv = req_yield_value;
      go_valid = req_valid && !req_fire;
      go_hold = 1'b0;
      if (!reset && !go_valid && pending_words.size() != 0) begin
         if (pending_words[0].kind == STEP_HOLD) begin
            void'(pending_words.pop_front());
            go_hold = 1'b1;
         end else if (pending_words[0].kind == STEP_DRAIN) begin
            if (expected_results.size() == 0)
               void'(pending_words.pop_front());
         end else if ((words_taken >= QUIET_LO && words_taken < QUIET_HI) ||
                      $urandom_range(0, 99) >= IDLE_PCT) begin
            nxt = pending_words.pop_front();
            go_valid = 1'b1;
         end
      end
      req_valid <= go_valid;
      req_func <= nxt.func;
      req_context_in <= nxt.ctx;
      req_new_is_thread <= nxt.thr;
      req_target_task <= nxt.tgt;
      req_yield_value <= nxt.yv;
      hold_go <= go_hold;
   end

   // accepted request words feed the predictor
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(predict_result(func_type'(req_func), req_context_in,
                                                   req_new_is_thread, req_target_task,
                                                   req_yield_value));
         words_taken <= words_taken + 1;
      end
   end

   // response stall, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // response checker
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response word: accepted %0b chosen %0d context %08h",
                        rsp_accepted, rsp_chosen_task, rsp_context_out);
            mismatches <= mismatches + 1;
         end else begin
            want = expected_results.pop_front();
            if (rsp_accepted !== want.accepted || rsp_chosen_task !== want.chosen_task ||
                rsp_context_out !== want.context_out) begin
               if (mismatches < 10)
                  $display("response word %0d: exp acc %0b task %0d ctx %08h, got %0b %0d %08h",
                           results_seen, want.accepted, want.chosen_task, want.context_out,
                           rsp_accepted, rsp_chosen_task, rsp_context_out);
               mismatches <= mismatches + 1;
            end
         end
      end
   end

endmodule
